@@ rtl/tsfb_pkg.sv @@
// Shared types and constants for the TCP SYN frame builder.
// No dependencies; imported by the front, queue, back and top-level modules.
`default_nettype none

package tsfb_pkg;

	typedef logic [1:0] status_t;

	localparam status_t STATUS_OK      = 2'd0;
	localparam status_t STATUS_TOO_BIG = 2'd1;
	localparam status_t STATUS_NO_BUF  = 2'd2;

	localparam int unsigned IN_TDATA_W  = 216;
	localparam int unsigned OUT_TDATA_W = 72;

	// One classified request with both checksums resolved.
	typedef struct packed {
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] ip_csum;
		logic [15:0] tcp_csum;
		status_t     status;
	} desc_t;

endpackage

`default_nettype wire

@@ rtl/tsfb_front.sv @@
// Front end: holds the payload limit, accepts requests, classifies them and
// resolves the IPv4 and TCP checksums over one register stage. Uses tsfb_pkg.
`default_nettype none

module tsfb_front (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire  [tsfb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input  wire                               cfg_we,
	input  wire  [15:0]                       cfg_wdata,
	output logic                              push_valid,
	input  wire                               push_ready,
	output tsfb_pkg::desc_t                   push_data
);
	import tsfb_pkg::*;

	// Fixed IPv4 header words: 0x4500, 0x0028, 0x4000, 0x4006.
	localparam logic [18:0] IP_CONST  = 19'h0C52E;
	// Protocol 6 + TCP length 20, offset/flags 0x5002, window 0xffff.
	localparam logic [19:0] TCP_CONST = 20'h1501B;

	function automatic logic [15:0] fold_not(input logic [19:0] sum);
		logic [16:0] s1;
		logic [15:0] s2;
		s1 = 17'(sum[15:0]) + 17'(sum[19:16]);
		s2 = s1[15:0] + 16'(s1[16]);
		return ~s2;
	endfunction

	logic [15:0] max_payload_len_q;

	logic [47:0] src_mac, dst_mac;
	logic [31:0] src_ip, dst_ip;
	logic [15:0] src_port, dst_port, payload_len;
	logic        buffer_free;
	logic        accept;

	logic        valid_s1;
	logic [47:0] src_mac_s1, dst_mac_s1;
	logic [31:0] src_ip_s1, dst_ip_s1;
	logic [15:0] src_port_s1, dst_port_s1;
	logic [17:0] addr_sum_s1;
	logic [16:0] port_sum_s1;
	status_t     status_s1;

	logic [18:0] ip_sum;
	logic [19:0] tcp_sum;
	status_t     status_in;

	assign src_mac     = s_axis_tdata[47:0];
	assign dst_mac     = s_axis_tdata[95:48];
	assign src_ip      = s_axis_tdata[127:96];
	assign dst_ip      = s_axis_tdata[159:128];
	assign src_port    = s_axis_tdata[175:160];
	assign dst_port    = s_axis_tdata[191:176];
	assign payload_len = s_axis_tdata[207:192];
	assign buffer_free = s_axis_tdata[208];

	assign s_axis_tready = !valid_s1 || push_ready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Length check wins over the buffer check.
	always_comb begin
		if (payload_len > max_payload_len_q) begin
			status_in = STATUS_TOO_BIG;
		end else if (!buffer_free) begin
			status_in = STATUS_NO_BUF;
		end else begin
			status_in = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_len_q <= 16'd1460;
		end else if (cfg_we) begin
			max_payload_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_mac_s1  <= src_mac;
			dst_mac_s1  <= dst_mac;
			src_ip_s1   <= src_ip;
			dst_ip_s1   <= dst_ip;
			src_port_s1 <= src_port;
			dst_port_s1 <= dst_port;
			addr_sum_s1 <= 18'(src_ip[31:16]) + 18'(src_ip[15:0])
			             + 18'(dst_ip[31:16]) + 18'(dst_ip[15:0]);
			port_sum_s1 <= 17'(src_port) + 17'(dst_port);
			status_s1   <= status_in;
		end
	end

	assign ip_sum  = 19'(addr_sum_s1) + IP_CONST;
	assign tcp_sum = 20'(addr_sum_s1) + 20'(port_sum_s1) + TCP_CONST;

	assign push_valid = valid_s1;

	always_comb begin
		push_data.dst_mac  = dst_mac_s1;
		push_data.src_mac  = src_mac_s1;
		push_data.src_ip   = src_ip_s1;
		push_data.dst_ip   = dst_ip_s1;
		push_data.src_port = src_port_s1;
		push_data.dst_port = dst_port_s1;
		push_data.ip_csum  = fold_not(20'(ip_sum));
		push_data.tcp_csum = fold_not(tcp_sum);
		push_data.status   = status_s1;
	end

endmodule

`default_nettype wire

@@ rtl/tsfb_queue.sv @@
// Short descriptor queue that decouples the front end from the serializer.
// Uses tsfb_pkg for the descriptor type.
`default_nettype none

module tsfb_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push_valid,
	output logic             push_ready,
	input  tsfb_pkg::desc_t  push_data,
	output logic             pop_valid,
	input  wire              pop,
	output tsfb_pkg::desc_t  pop_data
);
	import tsfb_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	desc_t             entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count above depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CNT_W'(DEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

@@ rtl/tsfb_back.sv @@
// Back end: walks the head descriptor through its header words and drives
// the registered output beat. Uses tsfb_pkg.
`default_nettype none

module tsfb_back (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               head_valid,
	input  tsfb_pkg::desc_t                   head,
	output logic                              pop,
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	output logic [tsfb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic                              m_axis_tlast,
	output logic [1:0]                        m_axis_tuser
);
	import tsfb_pkg::*;

	localparam logic [2:0] WORD_ETH_DST = 3'd0;
	localparam logic [2:0] WORD_ETH_SRC = 3'd1;
	localparam logic [2:0] WORD_IP_MID  = 3'd2;
	localparam logic [2:0] WORD_IP_ADDR = 3'd3;
	localparam logic [2:0] WORD_PORTS   = 3'd4;
	localparam logic [2:0] WORD_TCP_SEQ = 3'd5;
	localparam logic [2:0] WORD_TCP_END = 3'd6;

	localparam logic [3:0] BYTES_FULL = 4'd8;
	localparam logic [3:0] BYTES_TAIL = 4'd6;
	localparam logic [3:0] BYTES_NONE = 4'd0;

	logic [2:0]  word_q;
	logic        valid_q;
	logic [63:0] frame_q;
	logic [3:0]  bytes_q;
	logic        last_q;
	status_t     status_q;

	logic        load, is_err, word_last;
	logic [63:0] word_data;

	assign load      = head_valid && (!valid_q || m_axis_tready);
	assign is_err    = head.status != STATUS_OK;
	assign word_last = is_err || word_q == WORD_TCP_END;
	assign pop       = load && word_last;

	always_comb begin
		unique case (word_q)
			WORD_ETH_DST: word_data = {head.dst_mac, head.src_mac[47:32]};
			WORD_ETH_SRC: word_data = {head.src_mac[31:0], 16'h0800, 8'h45, 8'h00};
			WORD_IP_MID:  word_data = {16'h0028, 16'h0000, 16'h4000, 8'h40, 8'h06};
			WORD_IP_ADDR: word_data = {head.ip_csum, head.src_ip, head.dst_ip[31:16]};
			WORD_PORTS:   word_data = {head.dst_ip[15:0], head.src_port, head.dst_port,
			                           16'h0000};
			WORD_TCP_SEQ: word_data = {48'h0, 8'h50, 8'h02};
			WORD_TCP_END: word_data = {16'hffff, head.tcp_csum, 32'h0};
			default:      word_data = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			word_q  <= WORD_ETH_DST;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				word_q  <= word_last ? WORD_ETH_DST : word_q + 3'd1;
			end else if (m_axis_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q  <= is_err ? 64'h0 : word_data;
			bytes_q  <= is_err ? BYTES_NONE
			          : (word_q == WORD_TCP_END) ? BYTES_TAIL : BYTES_FULL;
			last_q   <= word_last;
			status_q <= head.status;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {4'h0, bytes_q, frame_q};
	assign m_axis_tlast  = last_q;
	assign m_axis_tuser  = status_q;

	a_word_bound: assert property (@(posedge clk) disable iff (!arst_n)
		word_q <= WORD_TCP_END)
		else $error("word index past the tail word");

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && status_q != STATUS_OK) |-> (last_q && bytes_q == BYTES_NONE))
		else $error("reject beat not a single empty last beat");

	a_tail_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && status_q == STATUS_OK) |-> (last_q == (bytes_q == BYTES_TAIL)))
		else $error("last flag out of step with tail word");

	a_err_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(load && is_err) |=> word_q == WORD_ETH_DST)
		else $error("reject did not restart the word index");

endmodule

`default_nettype wire

@@ rtl/tcp_syn_frame_builder_core.sv @@
// Top level of the TCP SYN frame builder: front end, descriptor queue and
// serializer. Depends on tsfb_pkg, tsfb_front, tsfb_queue and tsfb_back.
`default_nettype none

// Each request on the slave stream carries MAC and IPv4 addresses, TCP ports,
// a payload length and a buffer-free flag. A request whose payload length is
// above the programmed limit (cfg_wdata, reset 1460) yields one beat with
// status 1; otherwise one with buffer_free low yields one beat with status 2.
// Both reject beats carry zero data, byte count 0 and tlast. A good request
// yields seven beats holding the 54-byte Ethernet/IPv4/TCP SYN header, first
// wire byte in the top byte of frame_word: six beats of 8 bytes and a last
// beat of 6 bytes whose two low bytes are zero. IPv4 carries DF, TTL 64,
// total length 40 and its header checksum; TCP carries SYN, data offset 5,
// window 0xffff and its pseudo-header checksum. Throughput is set by the
// 8-byte output beat, with beats leaving back to back while tready stays
// high. The front end computes checksums in one register stage and hands
// descriptors to a QUEUE_DEPTH-entry queue, so new requests keep being
// accepted while the serializer is still sending, as long as the queue has
// room; with an empty pipeline the first beat passes the front register,
// then the queue, then the output register.
// Write the limit only while the block is idle.
module tcp_syn_frame_builder_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire          clk,
	input  wire          arst_n,
	// Request stream.
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// [47:0] src_mac, [95:48] dst_mac, [127:96] src_ip, [159:128] dst_ip,
	// [175:160] src_port, [191:176] dst_port, [207:192] payload_len,
	// [208] buffer_free, [215:209] zero
	input  wire  [215:0] s_axis_tdata,
	// Frame stream.
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// [63:0] frame_word, [67:64] byte_count, [71:68] zero
	output logic [71:0]  m_axis_tdata,
	output logic         m_axis_tlast,
	// [1:0] status: 0 ok, 1 payload too big, 2 no buffer
	output logic [1:0]   m_axis_tuser,
	// Payload length limit.
	input  wire          cfg_we,
	input  wire  [15:0]  cfg_wdata
);
	import tsfb_pkg::*;

	desc_t push_data, head;
	logic  push_valid, push_ready;
	logic  head_valid, pop;

	// Classify and checksum; advance one request per cycle when the queue has room.
	tsfb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_data     (push_data)
	);

	// Hold finished descriptors so each side can stall on its own.
	tsfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (head_valid),
		.pop        (pop),
		.pop_data   (head)
	);

	// Serialize the head descriptor; drop it after its last beat is loaded.
	tsfb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

@@ bench/tcp_syn_frame_builder_core_test.sv @@
// Self-checking bench for tcp_syn_frame_builder_core: drives requests and checks every frame beat.
// A small scoreboard class predicts the header words and reject beats.
// Depends on tsfb_pkg and the RTL of the frame builder.
`default_nettype none

module tcp_syn_frame_builder_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tsfb_pkg::*;

	// Fixed header fields of the generated frame.
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  IP_VER_IHL     = 8'h45;
	localparam logic [15:0] IP_TOTAL_LEN   = 16'd40;
	localparam logic [15:0] IP_FLAGS_DF    = 16'h4000;
	localparam logic [7:0]  IP_TTL         = 8'd64;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [15:0] TCP_HDR_LEN    = 16'd20;
	localparam logic [7:0]  TCP_DOFF       = 8'h50;
	localparam logic [7:0]  TCP_FLAG_SYN   = 8'h02;
	localparam logic [15:0] TCP_WINDOW     = 16'hffff;
	localparam logic [15:0] RESET_LIMIT    = 16'd1460;

	localparam int WORDS_PER_FRAME = 7;
	localparam int FULL_BYTES      = 8;
	localparam int LAST_BYTES      = 6;
	localparam int DRAIN_CYCLES    = 8;
	localparam int MAX_REPORTS     = 10;

	typedef struct {
		logic [47:0] src_mac;
		logic [47:0] dst_mac;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] payload_len;
		logic        buffer_free;
	} syn_request_t;

	typedef struct {
		logic [63:0] word;
		logic [3:0]  bytes;
		logic        is_last;
		status_t     status;
	} frame_beat_t;

	// Predict the beats of each accepted request and compare them in order.
	class frame_scoreboard;
		logic [15:0]  payload_limit = RESET_LIMIT;
		frame_beat_t  expected_beats[$];
		int unsigned  errors = 0;

		function logic [15:0] ones_fold(logic [31:0] sum);
			sum = {16'd0, sum[15:0]} + {16'd0, sum[31:16]};
			sum = {16'd0, sum[15:0]} + {16'd0, sum[31:16]};
			return ~sum[15:0];
		endfunction

		function void push_reject(status_t why);
			frame_beat_t b;
			b.word    = '0;
			b.bytes   = '0;
			b.is_last = 1'b1;
			b.status  = why;
			expected_beats.push_back(b);
		endfunction

		function void note_request(syn_request_t r);
			logic [31:0]  ip_sum;
			logic [31:0]  tcp_sum;
			logic [15:0]  ip_csum;
			logic [15:0]  tcp_csum;
			logic [447:0] hdr;
			frame_beat_t  b;
			// Length check takes priority over the buffer check.
			if (r.payload_len > payload_limit) begin
				push_reject(STATUS_TOO_BIG);
				return;
			end
			if (!r.buffer_free) begin
				push_reject(STATUS_NO_BUF);
				return;
			end
			ip_sum = {IP_VER_IHL, 8'h00} + IP_TOTAL_LEN + IP_FLAGS_DF + {IP_TTL, PROTO_TCP}
				+ r.src_ip[31:16] + r.src_ip[15:0] + r.dst_ip[31:16] + r.dst_ip[15:0];
			ip_csum = ones_fold(ip_sum);
			// Pseudo-header plus the TCP header with a zero checksum field.
			tcp_sum = r.src_ip[31:16] + r.src_ip[15:0] + r.dst_ip[31:16] + r.dst_ip[15:0]
				+ PROTO_TCP + TCP_HDR_LEN + r.src_port + r.dst_port
				+ {TCP_DOFF, TCP_FLAG_SYN} + TCP_WINDOW;
			tcp_csum = ones_fold(tcp_sum);
			hdr = {r.dst_mac, r.src_mac, ETHERTYPE_IPV4,
				IP_VER_IHL, 8'h00, IP_TOTAL_LEN, 16'h0000, IP_FLAGS_DF, IP_TTL, PROTO_TCP,
				ip_csum, r.src_ip, r.dst_ip,
				r.src_port, r.dst_port, 32'h0, 32'h0, TCP_DOFF, TCP_FLAG_SYN, TCP_WINDOW,
				tcp_csum, 16'h0000,
				16'h0000};
			for (int k = 0; k < WORDS_PER_FRAME; k++) begin
				b.word    = hdr[447 - 64 * k -: 64];
				b.is_last = (k == WORDS_PER_FRAME - 1);
				b.bytes   = b.is_last ? 4'(LAST_BYTES) : 4'(FULL_BYTES);
				b.status  = STATUS_OK;
				expected_beats.push_back(b);
			end
		endfunction

		function void check_beat(logic [63:0] word, logic [3:0] bytes, logic is_last,
			status_t status);
			frame_beat_t want;
			if (expected_beats.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected beat: word %h bytes %0d last %b status %0d",
						word, bytes, is_last, status);
				return;
			end
			want = expected_beats.pop_front();
			if (word !== want.word || bytes !== want.bytes || is_last !== want.is_last ||
				status !== want.status) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("beat mismatch: expected word %h bytes %0d last %b status %0d",
						want.word, want.bytes, want.is_last, want.status);
					$display("                   got word %h bytes %0d last %b status %0d",
						word, bytes, is_last, status);
				end
			end
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [215:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [71:0]  m_axis_tdata;
	logic         m_axis_tlast;
	logic [1:0]   m_axis_tuser;
	logic         cfg_we = 1'b0;
	logic [15:0]  cfg_wdata = '0;

	frame_scoreboard sb = new();

	// Sender burst state; gaps are switched off for some phases.
	int  burst_left = 0;
	bit  sender_gaps = 1'b0;

	// Receiver stall state.
	int unsigned rx_cycle = 0;
	int          stall_left = 0;

	tcp_syn_frame_builder_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Ending in the time limit means something hung.
	initial begin
		#400000;
		$display("** tcp_syn_frame_builder_core: FAILED **");
		$finish;
	end

	// Check every output beat as it is accepted, then pick the next ready value.
	// The stall pattern rotates through free flow, regular stalls, random
	// stalls and runs of stalls.
	always @(posedge clk) begin
		if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
			sb.check_beat(m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tlast, m_axis_tuser);
		rx_cycle <= rx_cycle + 1;
		case (rx_cycle[8:6])
			3'd2: m_axis_tready <= (rx_cycle[1:0] != 2'd0);
			3'd3: m_axis_tready <= ($urandom_range(0, 3) != 0);
			3'd4: begin
				if (stall_left > 0) begin
					m_axis_tready <= 1'b0;
					stall_left <= stall_left - 1;
				end else if ($urandom_range(0, 5) == 0) begin
					m_axis_tready <= 1'b0;
					stall_left <= $urandom_range(0, 7);
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
			3'd5: m_axis_tready <= 1'($urandom_range(0, 1));
			default: m_axis_tready <= 1'b1;
		endcase
	end

	function automatic syn_request_t make_request(logic [47:0] smac, logic [47:0] dmac,
		logic [31:0] sip, logic [31:0] dip, logic [15:0] sport, logic [15:0] dport,
		logic [15:0] plen, logic bfree);
		syn_request_t r;
		r.src_mac     = smac;
		r.dst_mac     = dmac;
		r.src_ip      = sip;
		r.dst_ip      = dip;
		r.src_port    = sport;
		r.dst_port    = dport;
		r.payload_len = plen;
		r.buffer_free = bfree;
		return r;
	endfunction

	// Random request; most lengths sit at or under the limit, some just above it.
	function automatic syn_request_t random_request(logic [15:0] limit);
		syn_request_t r;
		int pick;
		r.src_mac  = {16'($urandom()), $urandom()};
		r.dst_mac  = {16'($urandom()), $urandom()};
		r.src_ip   = $urandom();
		r.dst_ip   = $urandom();
		r.src_port = 16'($urandom());
		r.dst_port = 16'($urandom());
		pick = $urandom_range(0, 9);
		case (pick)
			6: r.payload_len = limit;
			7: r.payload_len = (limit == 16'hffff) ? limit : limit + 16'd1;
			8, 9: r.payload_len = 16'($urandom());
			default: r.payload_len = 16'($urandom_range(0, limit));
		endcase
		r.buffer_free = ($urandom_range(0, 7) != 0);
		return r;
	endfunction

	// Present one request and hold it until the block takes the beat.
	task automatic send_request(syn_request_t r);
		int gap;
		if (sender_gaps && burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, r.buffer_free, r.payload_len, r.dst_port, r.src_port,
			r.dst_ip, r.src_ip, r.dst_mac, r.src_mac};
		do
			@(posedge clk);
		while (s_axis_tready !== 1'b1);
		sb.note_request(r);
		if (burst_left > 0)
			burst_left--;
	endtask

	// Drop valid and hold off until every predicted beat has come out.
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the limit; only called with the block idle.
	task automatic set_payload_limit(logic [15:0] limit);
		cfg_wdata <= limit;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.payload_limit = limit;
	endtask

	initial begin
		logic [15:0] limit;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part, first with the reset limit still in place.
		send_request(make_request('0, '0, '0, '0, '0, '0, 16'd0, 1'b1));
		send_request(make_request('1, '1, '1, '1, '1, '1, RESET_LIMIT, 1'b1));
		send_request(make_request(48'haaaa_aaaa_aaaa, 48'h5555_5555_5555, 32'haaaa_aaaa,
			32'h5555_5555, 16'haaaa, 16'h5555, 16'd64, 1'b1));
		send_request(make_request(48'h0200_0000_0001, 48'hffff_ffff_ffff, 32'hc0a8_0001,
			32'hffff_ffff, 16'd1234, 16'd80, RESET_LIMIT + 16'd1, 1'b1));
		// Too-big wins over no-buffer.
		send_request(make_request('1, '0, '1, '0, 16'd443, 16'd1, 16'hffff, 1'b0));
		send_request(make_request('0, '1, '0, '1, 16'd1, 16'd443, 16'd10, 1'b0));
		send_request(make_request(48'h0123_4567_89ab, 48'hcdef_0123_4567, 32'h0a00_0001,
			32'h0a00_0002, 16'd49152, 16'd22, RESET_LIMIT, 1'b1));
		wait_drain();

		// Zero limit: only empty payloads pass.
		set_payload_limit(16'd0);
		send_request(make_request('1, '1, '1, '1, '1, '1, 16'd0, 1'b1));
		send_request(make_request('0, '0, '0, '0, '0, '0, 16'd1, 1'b1));
		send_request(make_request('0, '0, '0, '0, '0, '0, 16'd0, 1'b0));
		wait_drain();

		// Full limit: nothing is too big.
		set_payload_limit(16'hffff);
		send_request(make_request('1, '0, '1, '0, '1, '0, 16'hffff, 1'b1));
		send_request(make_request('0, '1, '0, '1, '0, '1, 16'hffff, 1'b0));
		send_request(make_request(48'h5555_5555_5555, 48'haaaa_aaaa_aaaa, 32'h5555_5555,
			32'haaaa_aaaa, 16'h5555, 16'haaaa, 16'h8000, 1'b1));
		wait_drain();

		// Random phases, each under its own limit; the first runs without sender gaps.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: limit = RESET_LIMIT;
				1: limit = 16'($urandom());
				2: limit = 16'hffff;
				default: limit = 16'($urandom_range(0, 200));
			endcase
			set_payload_limit(limit);
			sender_gaps = (ph != 0);
			for (int i = 0; i < 30; i++) begin
				// Pause mid-phase until the output side has caught up.
				if (ph == 2 && i == 15)
					wait_drain();
				send_request(random_request(limit));
			end
			wait_drain();
		end

		repeat (4 * DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("** tcp_syn_frame_builder_core: PASSED **");
		else
			$display("** tcp_syn_frame_builder_core: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
